@@ sv/ppg_sample_finger_qualifier_macros.svh @@
// Assertion macros used by the checker file.
// Every property is sampled on the rising edge of i_clk and disabled in reset.
`ifndef PPG_SAMPLE_FINGER_QUALIFIER_MACROS_SVH
`define PPG_SAMPLE_FINGER_QUALIFIER_MACROS_SVH

// Condition that holds on every clock edge out of reset.
`define PPG_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ppgfq_pkg.sv @@
// ----------------------------------------------------------------------------
// ppgfq_pkg
// Shared widths, codes and reset values of the PPG sample finger qualifier.
// ----------------------------------------------------------------------------
package ppgfq_pkg;

    localparam int SAMPLE_W    = 18;
    localparam int WORD_W      = 24;
    localparam int COUNT_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;

    // Input beat: tdata = red_word, ir_word ; tuser = data_ready
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 1;

    // Output beat: tdata = red_sample, ir_sample, red_low, red_high,
    // finger_now, finger_flag, zero pad ; tuser = status
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = STATUS_W;

    localparam int OUT_RED_LSB  = 0;
    localparam int OUT_IR_LSB   = 18;
    localparam int OUT_LOW_LSB  = 36;
    localparam int OUT_HIGH_LSB = 54;
    localparam int OUT_NOW_BIT  = 72;
    localparam int OUT_FLAG_BIT = 73;
    localparam int OUT_USED_W   = 74;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_SAMPLE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NODATA  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIM  = 2'd3;

    // Reset values
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 18'd50000;
    localparam logic [COUNT_W-1:0]  RST_NEEDED    = 8'd5;
    localparam logic [COUNT_W-1:0]  RST_CEILING   = 8'd10;
    localparam logic [COUNT_W-1:0]  RST_POLL_LIM  = 8'd100;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 18'h3FFFF;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [COUNT_W-1:0]  t_count;

endpackage

@@ sv/ppg_sample_finger_qualifier.sv @@
// An accepted input beat passes the input register, then the result register,
// where it waits while the sink stalls. The qualifier state updates per beat.
// Throughput: one beat per cycle unless the sink stalls.
// Reset: synchronous, active low; clears config to defaults, running min/max,
// poll and stable counters and the detected flag; both stages empty.
// ----------------------------------------------------------------------------
// ppg_sample_finger_qualifier
// Poll handling, red min/max tracking and IR finger qualification.
// ----------------------------------------------------------------------------
module ppg_sample_finger_qualifier (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [ppgfq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ppgfq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ppgfq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // red_word, ir_word
    input  logic [ppgfq_pkg::IN_TUSER_W-1:0]      s_axis_tuser,  // data_ready
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // red_sample, ir_sample, red_low, red_high, finger_now, finger_flag, pad
    output logic [ppgfq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [ppgfq_pkg::OUT_TUSER_W-1:0]     m_axis_tuser   // status
);
    import ppgfq_pkg::*;

    // configuration
    t_sample r_threshold;
    t_count  r_needed, r_ceiling, r_poll_lim;

    // input stage
    logic                  r_in_valid;
    logic                  r_in_ready_flag;
    logic [WORD_W-1:0]     r_red_word, r_ir_word;

    // qualifier state
    t_sample r_low_red, r_high_red, r_prev_ir;
    t_count  r_stable_cnt, r_polls;
    logic    r_detected;

    // result stage
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    t_sample               r_out_red, r_out_ir, r_out_low, r_out_high;
    logic                  r_out_now, r_out_flag;

    // next values
    t_sample n_low_red, n_high_red, n_prev_ir;
    t_count  n_stable_cnt, n_polls;
    logic    n_detected, n_now;
    logic [STATUS_W-1:0] n_status;

    t_sample w_red, w_ir, w_delta, w_out_red, w_out_ir;
    logic [COUNT_W:0]    w_poll_inc;
    logic [SAMPLE_W+2:0] w_five_d;
    t_count              w_cnt_inc;
    logic                w_over, w_stable;

    logic w_out_free, w_advance;

    // handshake: result register frees when empty or taken
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_needed    <= RST_NEEDED;
            r_ceiling   <= RST_CEILING;
            r_poll_lim  <= RST_POLL_LIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                REG_NEEDED:    r_needed    <= i_cfg_data[COUNT_W-1:0];
                REG_CEILING:   r_ceiling   <= i_cfg_data[COUNT_W-1:0];
                REG_POLL_LIM:  r_poll_lim  <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_ready_flag <= s_axis_tuser[0];
            r_red_word      <= s_axis_tdata[WORD_W-1:0];
            r_ir_word       <= s_axis_tdata[2*WORD_W-1:WORD_W];
        end
    end

    // unpack and arithmetic terms
    assign w_red      = r_red_word[SAMPLE_W-1:0];
    assign w_ir       = r_ir_word[SAMPLE_W-1:0];
    assign w_poll_inc = {1'b0, r_polls} + {{COUNT_W{1'b0}}, 1'b1};
    assign w_over     = w_ir > r_threshold;
    assign w_delta    = (w_ir > r_prev_ir) ? (w_ir - r_prev_ir) : (r_prev_ir - w_ir);
    // delta < prev/5  <=>  5*(delta+1) <= prev
    assign w_five_d   = ({3'b000, w_delta} << 2) + {3'b000, w_delta} + 21'd5;
    assign w_stable   = w_five_d <= {3'b000, r_prev_ir};
    assign w_cnt_inc  = (r_stable_cnt < r_ceiling) ? (r_stable_cnt + 8'd1) : r_stable_cnt;

    // next state and result
    always_comb begin
        n_low_red    = r_low_red;
        n_high_red   = r_high_red;
        n_prev_ir    = r_prev_ir;
        n_stable_cnt = r_stable_cnt;
        n_detected   = r_detected;
        n_polls      = r_polls;
        n_now        = 1'b0;
        n_status     = ST_SAMPLE;
        w_out_red    = '0;
        w_out_ir     = '0;
        if (!r_in_ready_flag) begin
            // empty poll
            if (w_poll_inc > {1'b0, r_poll_lim}) begin
                n_polls  = '0;
                n_status = ST_TIMEOUT;
            end else begin
                n_polls  = w_poll_inc[COUNT_W-1:0];
                n_status = ST_NODATA;
            end
        end else begin
            n_polls   = '0;
            w_out_red = w_red;
            w_out_ir  = w_ir;
            if (w_red < r_low_red)  n_low_red  = w_red;
            if (w_red > r_high_red) n_high_red = w_red;
            // finger qualifier
            if (w_over) begin
                n_prev_ir = w_ir;
                if (r_prev_ir != '0) begin
                    if (w_stable) begin
                        n_stable_cnt = w_cnt_inc;
                        if (w_cnt_inc >= r_needed) begin
                            n_detected = 1'b1;
                            n_now      = 1'b1;
                        end
                    end else begin
                        n_stable_cnt = '0;
                        n_detected   = 1'b0;
                    end
                end
            end else begin
                n_stable_cnt = '0;
                n_detected   = 1'b0;
                n_prev_ir    = '0;
            end
        end
    end

    // qualifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_red    <= SAMPLE_MAX;
            r_high_red   <= '0;
            r_prev_ir    <= '0;
            r_stable_cnt <= '0;
            r_detected   <= 1'b0;
            r_polls      <= '0;
        end else if (w_advance) begin
            r_low_red    <= n_low_red;
            r_high_red   <= n_high_red;
            r_prev_ir    <= n_prev_ir;
            r_stable_cnt <= n_stable_cnt;
            r_detected   <= n_detected;
            r_polls      <= n_polls;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_status   <= n_status;
            r_out_red  <= w_out_red;
            r_out_ir   <= w_out_ir;
            r_out_low  <= n_low_red;
            r_out_high <= n_high_red;
            r_out_now  <= n_now;
            r_out_flag <= n_detected;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, r_out_flag, r_out_now,
                            r_out_high, r_out_low, r_out_ir, r_out_red};

endmodule

@@ sv/ppgfq_checker.sv @@
// ----------------------------------------------------------------------------
// ppgfq_checker
// Port-level checks of the finger qualifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "ppg_sample_finger_qualifier_macros.svh"

module ppgfq_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [ppgfq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic [ppgfq_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
    import ppgfq_pkg::*;

    logic    w_is_sample, w_now, w_flag;
    t_sample w_red, w_ir, w_low, w_high;
    logic    w_now_ok, w_empty_ok, w_range_ok, w_stall;
    logic [OUT_TDATA_W+OUT_TUSER_W-1:0] w_beat;

    assign w_is_sample = m_axis_tuser == ST_SAMPLE;
    assign w_red  = m_axis_tdata[OUT_RED_LSB  +: SAMPLE_W];
    assign w_ir   = m_axis_tdata[OUT_IR_LSB   +: SAMPLE_W];
    assign w_low  = m_axis_tdata[OUT_LOW_LSB  +: SAMPLE_W];
    assign w_high = m_axis_tdata[OUT_HIGH_LSB +: SAMPLE_W];
    assign w_now  = m_axis_tdata[OUT_NOW_BIT];
    assign w_flag = m_axis_tdata[OUT_FLAG_BIT];

    // per-beat conditions
    assign w_now_ok   = !(m_axis_tvalid && w_now) || w_flag;
    assign w_empty_ok = !(m_axis_tvalid && !w_is_sample) ||
                        (w_red == '0 && w_ir == '0 && !w_now);
    assign w_range_ok = !(m_axis_tvalid && w_is_sample) ||
                        (w_low <= w_red && w_red <= w_high);
    assign w_stall    = m_axis_tvalid && !m_axis_tready;
    assign w_beat     = {m_axis_tuser, m_axis_tdata};

    // a confirmed finger is always reflected in the stored flag
    `PPG_ASSERT_ALWAYS(a_now_sets_flag, w_now_ok, "finger_now without finger_flag")

    // empty polls carry no samples and never confirm a finger
    `PPG_ASSERT_ALWAYS(a_empty_zero, w_empty_ok, "empty poll beat carries sample data")

    // after a sample the running red range brackets that sample
    `PPG_ASSERT_ALWAYS(a_red_range, w_range_ok, "red sample outside running range")

    // a stalled output beat holds
    `PPG_ASSERT_NEXT(a_out_hold, w_stall, m_axis_tvalid && $stable(w_beat), "stalled beat changed")

endmodule

bind ppg_sample_finger_qualifier ppgfq_checker u_ppgfq_checker (.*);
